### rtl/esig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF signature scanner package
// Shared widths, register indexes, configuration and result types.
// ----------------------------------------------------------------------------
package esig_pkg;

  // Default window depth and the fixed signature storage.
  localparam int unsigned SigMaxDefault = 32;
  localparam int unsigned SigBytes      = 32;
  localparam int unsigned SigIdxW       = 5;
  localparam int unsigned SigLenW       = 6;

  // Configuration port geometry: five 64-bit registers at 8-byte spacing.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;

  // Register indexes.
  localparam logic [2:0] RegSigLen   = 3'd0;
  localparam logic [2:0] RegSigWord0 = 3'd1;
  localparam logic [2:0] RegSigWord1 = 3'd2;
  localparam logic [2:0] RegSigWord2 = 3'd3;
  localparam logic [2:0] RegSigWord3 = 3'd4;

  localparam logic [SigLenW-1:0] SigLenReset = 6'd1;

  // Number of leading bytes that form the magic.
  localparam int unsigned MagicLen = 4;

  typedef struct packed {
    logic [SigLenW-1:0]             sig_len;
    logic [SigBytes-1:0][7:0]       sig_bytes;
  } esig_cfg_t;

  typedef struct packed {
    logic is_elf;
    logic sig_found;
    logic verdict_valid;
    logic infected;
  } esig_result_t;

  // ELF magic byte at a given position of the file header.
  function automatic logic [7:0] elf_magic(input logic [1:0] pos);
    logic [7:0] val;
    unique case (pos)
      2'd0:    val = 8'h7f;
      2'd1:    val = 8'h45;
      2'd2:    val = 8'h4c;
      default: val = 8'h46;
    endcase
    return val;
  endfunction

endpackage

### rtl/elf_signature_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF signature scanner
// Streams a file one byte per beat, checks the ELF magic and searches for a
// configured byte signature with an exact sliding-window compare.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one file byte per beat in s_axis_tdata, the
//   first-byte mark in s_axis_tuser and the last-byte mark in s_axis_tlast.
//   Every accepted beat yields exactly one result beat on the master stream:
//   is_elf, sig_found and infected in m_axis_tdata, and the verdict mark
//   (the echoed last-byte mark) in m_axis_tlast.
//   Each result beat is registered and appears in the cycle after its input
//   beat is accepted; throughput is one byte per cycle while the receiver
//   does not stall, set by the single output register after the window compare.
//   When the receiver stalls, the output register holds its beat and the
//   input is refused until that beat is taken; no beat is lost.
//   Reset clears the scan state to that of a fresh file, sets the signature
//   length to one and the signature bytes to zero.
//   The APB port writes the length and four 64-bit signature words at
//   byte addresses 0, 8, 16, 24 and 32; write it only while no beat is in
//   flight.
// ----------------------------------------------------------------------------
module elf_signature_scanner_unit #(
  parameter int unsigned SIG_MAX = esig_pkg::SigMaxDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                     s_axis_tuser,  // [0] file_start
  input  logic                           s_axis_tlast,  // file_end
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // [0] is_elf, [1] sig_found,
                                                        // [2] infected, [7:3] zero
  output logic                           m_axis_tlast,  // verdict_valid
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [esig_pkg::CfgAddrW-1:0]  paddr,
  input  logic [esig_pkg::CfgDataW-1:0]  pwdata,
  output logic [esig_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready
);

  esig_pkg::esig_cfg_t    cfg;
  esig_pkg::esig_result_t scan_res;
  esig_pkg::esig_result_t out_res;
  logic                   accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  esig_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esig_scan #(
    .SIG_MAX (SIG_MAX)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata),
    .file_start_i (s_axis_tuser[0]),
    .file_end_i   (s_axis_tlast),
    .cfg_i        (cfg),
    .res_o        (scan_res)
  );

  esig_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .res_i       (scan_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // Pack the result beat.
  assign m_axis_tdata = {5'b00000, out_res.infected, out_res.sig_found, out_res.is_elf};
  assign m_axis_tlast = out_res.verdict_valid;

endmodule

### rtl/esig_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF signature scanner configuration registers
// APB-style register file holding the signature length and its 32 bytes.
// ----------------------------------------------------------------------------
module esig_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [esig_pkg::CfgAddrW-1:0]  paddr,
  input  logic [esig_pkg::CfgDataW-1:0]  pwdata,
  output logic [esig_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output esig_pkg::esig_cfg_t            cfg_o
);

  logic [esig_pkg::SigLenW-1:0]  sig_len_q;
  logic [esig_pkg::CfgDataW-1:0] sig_word0_q;
  logic [esig_pkg::CfgDataW-1:0] sig_word1_q;
  logic [esig_pkg::CfgDataW-1:0] sig_word2_q;
  logic [esig_pkg::CfgDataW-1:0] sig_word3_q;
  logic [2:0]                    reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[esig_pkg::CfgAddrW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_len_q   <= esig_pkg::SigLenReset;
      sig_word0_q <= '0;
      sig_word1_q <= '0;
      sig_word2_q <= '0;
      sig_word3_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        esig_pkg::RegSigLen:   sig_len_q   <= pwdata[esig_pkg::SigLenW-1:0];
        esig_pkg::RegSigWord0: sig_word0_q <= pwdata;
        esig_pkg::RegSigWord1: sig_word1_q <= pwdata;
        esig_pkg::RegSigWord2: sig_word2_q <= pwdata;
        esig_pkg::RegSigWord3: sig_word3_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      esig_pkg::RegSigLen:   prdata = esig_pkg::CfgDataW'(sig_len_q);
      esig_pkg::RegSigWord0: prdata = sig_word0_q;
      esig_pkg::RegSigWord1: prdata = sig_word1_q;
      esig_pkg::RegSigWord2: prdata = sig_word2_q;
      esig_pkg::RegSigWord3: prdata = sig_word3_q;
      default:               prdata = '0;
    endcase
  end

  // Signature byte 0 sits in the lowest lane of word 0.
  assign cfg_o.sig_len   = sig_len_q;
  assign cfg_o.sig_bytes = {sig_word3_q, sig_word2_q, sig_word1_q, sig_word0_q};

endmodule

### rtl/esig_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF signature scanner scan state
// Byte window, magic check and sliding signature compare for one beat.
// ----------------------------------------------------------------------------
module esig_scan #(
  parameter int unsigned SIG_MAX = esig_pkg::SigMaxDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   file_start_i,
  input  logic                   file_end_i,
  input  esig_pkg::esig_cfg_t    cfg_i,
  output esig_pkg::esig_result_t res_o
);

  localparam int unsigned CntW = $clog2(SIG_MAX + 1);
  localparam logic [CntW-1:0] SeenMax = CntW'(SIG_MAX);
  localparam logic [CntW-1:0] MagicCnt = CntW'(esig_pkg::MagicLen);
  localparam logic [esig_pkg::SigLenW-1:0] LenMax = esig_pkg::SigLenW'(SIG_MAX);

  logic [7:0]      win_q    [SIG_MAX];
  logic [7:0]      win_d    [SIG_MAX];
  logic [7:0]      base_win [SIG_MAX];
  logic [CntW-1:0] seen_q, seen_d, base_seen;
  logic            magic_q, magic_d, base_magic;
  logic            found_q, found_d, base_found;
  logic [SIG_MAX-1:0] lane_ok;
  logic            len_ok;
  logic            match;
  logic            elf;
  logic [esig_pkg::SigLenW-1:0] len;

  assign len = cfg_i.sig_len;

  // A start mark scans the byte against a freshly cleared state.
  always_comb begin
    for (int i = 0; i < SIG_MAX; i++) begin
      base_win[i] = file_start_i ? 8'h00 : win_q[i];
    end
    base_seen  = file_start_i ? '0 : seen_q;
    base_magic = file_start_i ? 1'b1 : magic_q;
    base_found = file_start_i ? 1'b0 : found_q;
  end

  // Shift the new byte into the window and count bytes up to the depth.
  always_comb begin
    win_d[0] = data_byte_i;
    for (int i = 1; i < SIG_MAX; i++) begin
      win_d[i] = base_win[i-1];
    end
    seen_d = (base_seen == SeenMax) ? base_seen : base_seen + CntW'(1);
  end

  // Magic check over the first four bytes of the file.
  assign magic_d = base_magic &&
                   !((base_seen < MagicCnt) && (data_byte_i != esig_pkg::elf_magic(base_seen[1:0])));

  // Lane j holds the byte that must equal signature byte len-1-j.
  for (genvar j = 0; j < SIG_MAX; j++) begin : g_lane
    localparam logic [esig_pkg::SigLenW-1:0] LaneIdx = esig_pkg::SigLenW'(j);
    logic [esig_pkg::SigLenW-1:0] sig_idx;
    assign sig_idx    = len - LaneIdx - esig_pkg::SigLenW'(1);
    assign lane_ok[j] = (LaneIdx >= len) ||
                        (win_d[j] == cfg_i.sig_bytes[sig_idx[esig_pkg::SigIdxW-1:0]]);
  end

  assign len_ok  = (len != '0) && (len <= LenMax) &&
                   (esig_pkg::SigLenW'(seen_d) >= len);
  assign match   = len_ok && (&lane_ok);
  assign found_d = base_found || match;
  assign elf     = magic_d && (seen_d >= MagicCnt);

  assign res_o.is_elf        = elf;
  assign res_o.sig_found     = found_d;
  assign res_o.verdict_valid = file_end_i;
  assign res_o.infected      = file_end_i && elf && found_d;

  // Scan state advances on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SIG_MAX; i++) begin
        win_q[i] <= 8'h00;
      end
      seen_q  <= '0;
      magic_q <= 1'b1;
      found_q <= 1'b0;
    end else if (accept_i) begin
      for (int i = 0; i < SIG_MAX; i++) begin
        win_q[i] <= win_d[i];
      end
      seen_q  <= seen_d;
      magic_q <= magic_d;
      found_q <= found_d;
    end
  end

`ifndef SYNTHESIS
  // The found flag stays set until the next file starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !file_start_i && found_q |=> found_q)
    else $error("found flag cleared within a file");

  // A failed magic check cannot recover within the same file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !file_start_i && !magic_q |=> !magic_q)
    else $error("magic flag recovered within a file");

  // The byte count saturates at the window depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= SeenMax)
    else $error("byte count past window depth");

  // An infected verdict needs an ELF header and a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.infected |-> res_o.is_elf && res_o.sig_found && res_o.verdict_valid)
    else $error("infected verdict without its conditions");
`endif

endmodule

### rtl/esig_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ELF signature scanner output register
// Holds one result beat and takes the next while the current one is taken.
// ----------------------------------------------------------------------------
module esig_out (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  esig_pkg::esig_result_t res_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output esig_pkg::esig_result_t res_o
);

  logic                   valid_q, valid_d;
  esig_pkg::esig_result_t res_q;

  // Load whenever the register is empty or being drained this cycle.
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = in_valid_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
